>>> design/acs_pkg.sv
// Package for the attenuator code select block: mode and register codes,
// field widths, the standard code table and controller/datapath bundles.
`timescale 1ns / 1ps

package acs_pkg;

   localparam int STAGE_CNT       = 6;
   localparam int NUM_STAGES_DEF  = 6;
   localparam int MAX_ATTEN_DEF   = 500;

   localparam int REQ_W   = 12;
   localparam int STAGE_W = 9;
   localparam int CODE_W  = 6;
   localparam int MAXA_W  = 12;
   localparam int SUM_W   = 12;
   localparam int SQR_W   = 2 * STAGE_W;
   localparam int SQ_W    = SQR_W + 3;
   localparam int IDX_W   = 3;

   localparam logic [1:0] MODE_STD    = 2'd0;
   localparam logic [1:0] MODE_FA     = 2'd1;
   localparam logic [1:0] MODE_CUSTOM = 2'd2;

   localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [IDX_W-1:0] REG_STAGE_FIRST = 3'd1;
   localparam logic [IDX_W-1:0] REG_STAGE_LAST  = 3'd6;

   localparam logic [MAXA_W-1:0] STD_MAX_DB  = 12'd50;
   localparam logic [MAXA_W-1:0] STD_STEP_DB = 12'd10;
   localparam logic [MAXA_W-1:0] FA_MAX_DB   = 12'd66;

   localparam logic [CODE_W-1:0] STD_CODES [6] = '{6'h00, 6'h01, 6'h02, 6'h03, 6'h06, 6'h07};

   typedef struct packed {
      logic load;
      logic sq_step;
      logic search_step;
      logic out_load;
   } acs_cmd_type;

   typedef struct packed {
      logic custom;
      logic sq_last;
      logic mask_last;
   } acs_sts_type;

endpackage

>>> design/acs_ctrl.sv
// Controller state machine for the attenuator code select block.
// Depends on acs_pkg; drives the datapath through acs_cmd_type.
`timescale 1ns / 1ps

module acs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  acs_pkg::acs_sts_type sts,
   output acs_pkg::acs_cmd_type cmd
);
   import acs_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.custom ? ST_SQUARE : ST_FINISH;
            end
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            if (sts.sq_last) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.mask_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> design/acs_dp.sv
// Datapath for the attenuator code select block: configuration registers,
// square pass, two-stage mask search and the result register. Uses acs_pkg.
`timescale 1ns / 1ps

module acs_dp #(
   parameter int NUM_STAGES      = acs_pkg::NUM_STAGES_DEF,
   parameter int MAX_STAGE_ATTEN = acs_pkg::MAX_ATTEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [acs_pkg::IDX_W-1:0]   csr_index,
   input  logic [acs_pkg::STAGE_W-1:0] csr_wdata,
   input  logic [acs_pkg::REQ_W-1:0]   req_atten,
   input  acs_pkg::acs_cmd_type        cmd,
   output acs_pkg::acs_sts_type        sts,
   output logic [acs_pkg::CODE_W-1:0]  rsp_code,
   output logic                        rsp_ok,
   output logic [acs_pkg::MAXA_W-1:0]  rsp_max
);
   import acs_pkg::*;

   logic [1:0]         mode_ff;
   logic [STAGE_W-1:0] stage_ff [STAGE_CNT];
   logic [SQR_W-1:0]   sq_ff    [STAGE_CNT];

   logic [REQ_W-1:0]      req_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  reject_ff, reject_in;
   logic [NUM_STAGES-1:0] mask_ff, mask_in;

   logic [SUM_W-1:0]      p_sum_ff, p_sum_in;
   logic [SQ_W-1:0]       p_sq_ff, p_sq_in;
   logic                  p_valid_ff, p_valid_in;
   logic [NUM_STAGES-1:0] p_mask_ff;

   logic                  found_ff, found_in;
   logic [SQ_W-1:0]       best_sq_ff, best_sq_in;
   logic [NUM_STAGES-1:0] best_mask_ff, best_mask_in;
   logic [MAXA_W-1:0]     maxv_ff, maxv_in;

   logic [STAGE_W-1:0] stage_rd;
   logic [SQR_W-1:0]   sq_prod;

   logic [CODE_W-1:0] code_res;
   logic              ok_res;
   logic [MAXA_W-1:0] max_res;

   logic [CODE_W-1:0] rsp_code_ff;
   logic              rsp_ok_ff;
   logic [MAXA_W-1:0] rsp_max_ff;

   function automatic logic [CODE_W-1:0] fa_code(input logic [6:0] db_i);
      logic [6:0]        db;
      logic [CODE_W-1:0] code;
      db   = db_i;
      code = '0;
      if (db == 7'd32 || db >= 7'd36) begin
         code[5] = 1'b1;
         db      = db - 7'd32;
      end
      if (db == 7'd16 || db >= 7'd20) begin
         code[4] = 1'b1;
         db      = db - 7'd16;
      end
      if (db != 7'd0) begin
         db      = db - 7'd4;
         code[3] = 1'b1;
         if (db >= 7'd8) begin
            code[2] = 1'b1;
            db      = db - 7'd8;
         end
         if (db >= 7'd4) begin
            code[1] = 1'b1;
            db      = db - 7'd4;
         end
         if (db >= 7'd2) begin
            code[0] = 1'b1;
         end
      end
      return code;
   endfunction

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STD;
         for (int i = 0; i < STAGE_CNT; i++) begin
            stage_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_MODE) begin
            mode_ff <= csr_wdata[1:0];
         end else if (csr_index inside {[REG_STAGE_FIRST:REG_STAGE_LAST]}) begin
            stage_ff[csr_index - REG_STAGE_FIRST] <= csr_wdata;
         end
      end
   end

   // square pass: one stage per cycle
   assign stage_rd = stage_ff[idx_ff];
   assign sq_prod  = SQR_W'(stage_rd) * SQR_W'(stage_rd);

   always_comb begin
      idx_in    = idx_ff;
      reject_in = reject_ff;
      mask_in   = mask_ff;
      if (cmd.load) begin
         idx_in    = '0;
         reject_in = 1'b0;
         mask_in   = NUM_STAGES'(1);
      end
      if (cmd.sq_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (32'(stage_rd) > 32'(MAX_STAGE_ATTEN)) begin
            reject_in = 1'b1;
         end
      end
      if (cmd.search_step) begin
         mask_in = mask_ff + NUM_STAGES'(1);
      end
   end

   assign sts.custom    = (mode_ff == MODE_CUSTOM);
   assign sts.sq_last   = (idx_ff == IDX_W'(NUM_STAGES - 1));
   assign sts.mask_last = &mask_ff;

   // search stage 1: sums for the current mask
   always_comb begin
      p_sum_in   = '0;
      p_sq_in    = '0;
      p_valid_in = cmd.search_step;
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (mask_ff[s]) begin
            if (stage_ff[s] == '0) begin
               p_valid_in = 1'b0;
            end
            p_sum_in = p_sum_in + SUM_W'(stage_ff[s]);
            p_sq_in  = p_sq_in + SQ_W'(sq_ff[s]);
         end
      end
   end

   // search stage 2: track maximum and best match
   always_comb begin
      found_in     = found_ff;
      best_sq_in   = best_sq_ff;
      best_mask_in = best_mask_ff;
      maxv_in      = maxv_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         maxv_in  = '0;
      end else if (p_valid_ff) begin
         if (p_sum_ff > maxv_ff) begin
            maxv_in = p_sum_ff;
         end
         if (p_sum_ff == req_ff && (!found_ff || p_sq_ff <= best_sq_ff)) begin
            found_in     = 1'b1;
            best_sq_in   = p_sq_ff;
            best_mask_in = p_mask_ff;
         end
      end
   end

   // result for the current mode
   always_comb begin
      code_res = '0;
      ok_res   = 1'b0;
      max_res  = '0;
      case (mode_ff)
         MODE_FA: begin
            max_res = FA_MAX_DB;
            if (req_ff == '0) begin
               ok_res = 1'b1;
            end else if (req_ff >= 12'd4 && req_ff <= FA_MAX_DB && !req_ff[0]) begin
               ok_res   = 1'b1;
               code_res = fa_code(req_ff[6:0]);
            end
         end
         MODE_CUSTOM: begin
            ok_res = (req_ff == '0);
            if (!reject_ff) begin
               max_res = maxv_ff;
               if (found_ff) begin
                  ok_res   = 1'b1;
                  code_res = CODE_W'(best_mask_ff);
               end
            end
         end
         default: begin
            max_res = STD_MAX_DB;
            for (int i = 0; i < 6; i++) begin
               if (req_ff == MAXA_W'(i) * STD_STEP_DB) begin
                  ok_res   = 1'b1;
                  code_res = STD_CODES[i];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_atten;
      end
      if (cmd.sq_step) begin
         sq_ff[idx_ff] <= sq_prod;
      end
      if (cmd.out_load) begin
         rsp_code_ff <= code_res;
         rsp_ok_ff   <= ok_res;
         rsp_max_ff  <= max_res;
      end
      idx_ff       <= idx_in;
      reject_ff    <= reject_in;
      mask_ff      <= mask_in;
      p_sum_ff     <= p_sum_in;
      p_sq_ff      <= p_sq_in;
      p_mask_ff    <= mask_ff;
      best_sq_ff   <= best_sq_in;
      best_mask_ff <= best_mask_in;
      maxv_ff      <= maxv_in;
   end

   assign rsp_code = rsp_code_ff;
   assign rsp_ok   = rsp_ok_ff;
   assign rsp_max  = rsp_max_ff;

endmodule

>>> design/attenuator_code_select_core.sv
// Top level of the attenuator code select block: stream ports, controller
// and datapath. Uses acs_pkg, acs_ctrl and acs_dp.
// Standard and Fa modes go from accept straight to the finish state, where
// the result is registered. Custom mode first runs the square pass, then
// one stage mask per cycle through the search pipe and a drain state.
// One item at a time; a new beat is taken while the last result waits.
// Reset clears mode and stage registers to 0 and empties the result register.
`timescale 1ns / 1ps

module attenuator_code_select_core #(
   parameter int NUM_STAGES      = acs_pkg::NUM_STAGES_DEF,
   parameter int MAX_STAGE_ATTEN = acs_pkg::MAX_ATTEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [acs_pkg::IDX_W-1:0]   csr_index,
   input  logic [acs_pkg::STAGE_W-1:0] csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // requested_atten[11:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,  // control_code[5:0], max_atten[17:6]
   output logic                        rsp_tuser   // supported
);
   import acs_pkg::*;

   acs_cmd_type       cmd;
   acs_sts_type       sts;
   logic [CODE_W-1:0] code;
   logic [MAXA_W-1:0] max_atten;

   acs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   acs_dp #(
      .NUM_STAGES      (NUM_STAGES),
      .MAX_STAGE_ATTEN (MAX_STAGE_ATTEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_atten (req_tdata[REQ_W-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_code  (code),
      .rsp_ok    (rsp_tuser),
      .rsp_max   (max_atten)
   );

   assign rsp_tdata = {6'd0, max_atten, code};

endmodule
